FILE: rtl/core/deque_with_cursor_core_macros.svh
// ----------------------------------------------------------------------------
// deque_with_cursor_core_macros.svh
// Assertion macros for the deque with cursor core. Defining ASSERT_OFF
// compiles every check out.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_CURSOR_CORE_MACROS_SVH
`define DEQUE_WITH_CURSOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that holds outside reset.
`define DWC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("deque_with_cursor_core: check failed");

// Check that holds at every edge, reset included.
`define DWC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("deque_with_cursor_core: check failed");

`else

`define DWC_ASSERT(label, clk, rstn, prop)
`define DWC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/core/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared codes, widths and the controller command bundle for the deque
// with cursor core.
// ----------------------------------------------------------------------------
package dwc_pkg;

    // Default sizing
    localparam int DEFAULT_CAPACITY   = 256;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Fixed port field widths
    localparam int ACTION_WIDTH = 3;
    localparam int WORD_WIDTH   = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 9;

    // Request codes
    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_PUSH_LEFT    = 3'd0,
        ACT_PUSH_RIGHT   = 3'd1,
        ACT_POP_LEFT     = 3'd2,
        ACT_POP_RIGHT    = 3'd3,
        ACT_CURSOR_LEFT  = 3'd4,
        ACT_CURSOR_RIGHT = 3'd5,
        ACT_SET_CURSOR   = 3'd6,
        ACT_STATUS       = 3'd7
    } dwc_action_t;

    // Result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_EDGE  = 2'd3
    } dwc_status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // request accepted: commit indices, write/read store
        logic finish;  // store data ready and result slot free: load result
    } dwc_cmd_t;

    // Which shadow words take the store read data at finish
    typedef struct packed {
        logic left;
        logic right;
        logic cursor;
    } dwc_pend_t;

endpackage

FILE: rtl/core/dwc_ctrl.sv
// ----------------------------------------------------------------------------
// dwc_ctrl
// Request sequencer: accepts one request, waits in ST_EXEC for the registered store
// read, then loads the result register once it is free.
// ----------------------------------------------------------------------------
module dwc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output dwc_pkg::dwc_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    // Command decode
    always_comb begin
        cmd.start  = s_valid && s_ready_reg;
        cmd.finish = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    s_ready_reg <= 1'b1;
                    if (cmd.start) begin
                        s_ready_reg <= 1'b0;
                        state_reg   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (cmd.finish) begin
                        s_ready_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // result slot: filled at finish, emptied when taken
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/dwc_datapath.sv
// ----------------------------------------------------------------------------
// dwc_datapath
// Ring store, end and cursor indices, word count, shadow copies of the
// end and cursor words, and the result register.
// ----------------------------------------------------------------------------
module dwc_datapath #(
    parameter int CAPACITY   = dwc_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = dwc_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dwc_pkg::dwc_cmd_t                      cmd,
    input  logic [dwc_pkg::ACTION_WIDTH-1:0]       s_action,
    input  logic signed [dwc_pkg::WORD_WIDTH-1:0]  s_data_value,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_popped_value,
    output logic [dwc_pkg::STATUS_WIDTH-1:0]       m_status,
    output logic [dwc_pkg::COUNT_WIDTH-1:0]        m_item_count,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_left_value,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_right_value,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_cursor_value
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [IW-1:0]                idx_t;
    typedef logic [CW-1:0]                cnt_t;
    typedef logic signed [DATA_WIDTH-1:0] word_t;

    // Ring store
    word_t slot_mem [CAPACITY];
    word_t rd_data_reg;

    // Control state
    idx_t left_idx_reg,   left_idx_next;
    idx_t right_idx_reg,  right_idx_next;
    idx_t cursor_idx_reg, cursor_idx_next;
    cnt_t count_reg,      count_next;
    dwc_pkg::dwc_pend_t pend_reg, pend_next;

    // Payload state
    word_t left_word_reg,   left_word_next;
    word_t right_word_reg,  right_word_next;
    word_t cursor_word_reg, cursor_word_next;
    word_t popped_reg,      popped_next;
    dwc_pkg::dwc_status_t status_reg, status_next;

    // Store port controls
    logic  wr_en;
    idx_t  wr_addr;
    logic  rd_en;
    idx_t  rd_addr;

    dwc_pkg::dwc_action_t act;
    word_t                din;
    logic                 is_empty;
    logic                 is_full;
    logic                 has_two;
    word_t                left_final;
    word_t                right_final;
    word_t                cursor_final;

    function automatic idx_t step_left(input idx_t idx);
        return (idx == '0) ? IW'(CAPACITY - 1) : idx - 1'b1;
    endfunction

    function automatic idx_t step_right(input idx_t idx);
        return (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Sign-extend or truncate a stored word to the port width
    function automatic logic signed [dwc_pkg::WORD_WIDTH-1:0] to_port(input word_t w);
        return dwc_pkg::WORD_WIDTH'(w);
    endfunction

    assign act      = dwc_pkg::dwc_action_t'(s_action);
    assign din      = DATA_WIDTH'(s_data_value);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign has_two  = (count_reg > CW'(1));

    // Request decode: index updates, store access, status
    always_comb begin
        left_idx_next    = left_idx_reg;
        right_idx_next   = right_idx_reg;
        cursor_idx_next  = cursor_idx_reg;
        count_next       = count_reg;
        pend_next        = '0;
        status_next      = dwc_pkg::STATUS_DONE;
        popped_next      = '0;
        left_word_next   = left_word_reg;
        right_word_next  = right_word_reg;
        cursor_word_next = cursor_word_reg;
        wr_en            = 1'b0;
        wr_addr          = left_idx_reg;
        rd_en            = 1'b0;
        rd_addr          = left_idx_reg;

        unique case (act)
            dwc_pkg::ACT_PUSH_LEFT, dwc_pkg::ACT_PUSH_RIGHT: begin
                if (is_full) begin
                    status_next = dwc_pkg::STATUS_FULL;
                end else if (is_empty) begin
                    // first word: both ends and cursor land on it
                    wr_en            = 1'b1;
                    wr_addr          = left_idx_reg;
                    right_idx_next   = left_idx_reg;
                    cursor_idx_next  = left_idx_reg;
                    count_next       = CW'(1);
                    left_word_next   = din;
                    right_word_next  = din;
                    cursor_word_next = din;
                end else if (act == dwc_pkg::ACT_PUSH_LEFT) begin
                    left_idx_next  = step_left(left_idx_reg);
                    wr_en          = 1'b1;
                    wr_addr        = left_idx_next;
                    count_next     = count_reg + 1'b1;
                    left_word_next = din;
                end else begin
                    right_idx_next  = step_right(right_idx_reg);
                    wr_en           = 1'b1;
                    wr_addr         = right_idx_next;
                    count_next      = count_reg + 1'b1;
                    right_word_next = din;
                end
            end
            dwc_pkg::ACT_POP_LEFT, dwc_pkg::ACT_POP_RIGHT: begin
                if (is_empty) begin
                    status_next = dwc_pkg::STATUS_EMPTY;
                end else if (!has_two) begin
                    // last word leaves: everything back to slot zero
                    popped_next     = left_word_reg;
                    left_idx_next   = '0;
                    right_idx_next  = '0;
                    cursor_idx_next = '0;
                    count_next      = '0;
                end else if (act == dwc_pkg::ACT_POP_LEFT) begin
                    popped_next    = left_word_reg;
                    left_idx_next  = step_right(left_idx_reg);
                    rd_en          = 1'b1;
                    rd_addr        = left_idx_next;
                    pend_next.left = 1'b1;
                    count_next     = count_reg - 1'b1;
                    if (cursor_idx_reg == left_idx_reg) begin
                        cursor_idx_next  = left_idx_next;
                        pend_next.cursor = 1'b1;
                    end
                end else begin
                    popped_next     = right_word_reg;
                    right_idx_next  = step_left(right_idx_reg);
                    rd_en           = 1'b1;
                    rd_addr         = right_idx_next;
                    pend_next.right = 1'b1;
                    count_next      = count_reg - 1'b1;
                    if (cursor_idx_reg == right_idx_reg) begin
                        cursor_idx_next  = right_idx_next;
                        pend_next.cursor = 1'b1;
                    end
                end
            end
            dwc_pkg::ACT_CURSOR_LEFT: begin
                if (!has_two || cursor_idx_reg == left_idx_reg) begin
                    status_next = dwc_pkg::STATUS_EDGE;
                end else begin
                    cursor_idx_next  = step_left(cursor_idx_reg);
                    rd_en            = 1'b1;
                    rd_addr          = cursor_idx_next;
                    pend_next.cursor = 1'b1;
                end
            end
            dwc_pkg::ACT_CURSOR_RIGHT: begin
                if (!has_two || cursor_idx_reg == right_idx_reg) begin
                    status_next = dwc_pkg::STATUS_EDGE;
                end else begin
                    cursor_idx_next  = step_right(cursor_idx_reg);
                    rd_en            = 1'b1;
                    rd_addr          = cursor_idx_next;
                    pend_next.cursor = 1'b1;
                end
            end
            dwc_pkg::ACT_SET_CURSOR: begin
                if (is_empty) begin
                    status_next = dwc_pkg::STATUS_EMPTY;
                end else begin
                    wr_en            = 1'b1;
                    wr_addr          = cursor_idx_reg;
                    cursor_word_next = din;
                    if (cursor_idx_reg == left_idx_reg) begin
                        left_word_next = din;
                    end
                    if (cursor_idx_reg == right_idx_reg) begin
                        right_word_next = din;
                    end
                end
            end
            dwc_pkg::ACT_STATUS: begin
                if (is_empty) begin
                    status_next = dwc_pkg::STATUS_EMPTY;
                end
            end
            default: begin
                status_next = dwc_pkg::STATUS_DONE;
            end
        endcase
    end

    // Words after the request, with the store read merged in
    assign left_final   = pend_reg.left   ? rd_data_reg : left_word_reg;
    assign right_final  = pend_reg.right  ? rd_data_reg : right_word_reg;
    assign cursor_final = pend_reg.cursor ? rd_data_reg : cursor_word_reg;

    // Store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.start && wr_en) begin
            slot_mem[wr_addr] <= din;
        end
        if (cmd.start && rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Indices and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_idx_reg   <= '0;
            right_idx_reg  <= '0;
            cursor_idx_reg <= '0;
            count_reg      <= '0;
            pend_reg       <= '0;
        end else if (cmd.start) begin
            left_idx_reg   <= left_idx_next;
            right_idx_reg  <= right_idx_next;
            cursor_idx_reg <= cursor_idx_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
        end
    end

    // Shadow words and result register
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            left_word_reg   <= left_word_next;
            right_word_reg  <= right_word_next;
            cursor_word_reg <= cursor_word_next;
            popped_reg      <= popped_next;
            status_reg      <= status_next;
        end else if (cmd.finish) begin
            left_word_reg   <= left_final;
            right_word_reg  <= right_final;
            cursor_word_reg <= cursor_final;
            m_popped_value  <= to_port(popped_reg);
            m_status        <= status_reg;
            m_item_count    <= dwc_pkg::COUNT_WIDTH'(count_reg);
            if (count_reg == '0) begin
                m_left_value   <= '0;
                m_right_value  <= '0;
                m_cursor_value <= '0;
            end else begin
                m_left_value   <= to_port(left_final);
                m_right_value  <= to_port(right_final);
                m_cursor_value <= to_port(cursor_final);
            end
        end
    end

endmodule

FILE: rtl/core/deque_with_cursor_core.sv
// ----------------------------------------------------------------------------
// deque_with_cursor_core
// Bounded double-ended queue of signed words in a ring store, with a
// cursor that can move, be written and follows pops at its word.
// ----------------------------------------------------------------------------
//  channel   ports                            direction  one request / result
//  s_        s_valid s_ready s_action         in         action and data word
//            s_data_value
//  m_        m_valid m_ready m_popped_value   out        popped word, status,
//            m_status m_item_count m_left_...            count, end and cursor
//
//  For each request, the accept edge updates indices and issues at most one
//  store write or read; a later edge loads the result register from the
//  registered store read port. One request is in flight at a time.
//  s_ready returns at the same edge that loads the result; a result waiting on
//  m_ready holds the request in flight but never an accepted result.
//  Reset (aresetn low, synchronous) empties the deque; store contents stay
//  undefined and need no clearing pass.
// ----------------------------------------------------------------------------
`include "deque_with_cursor_core_macros.svh"

module deque_with_cursor_core #(
    parameter int CAPACITY   = dwc_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = dwc_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [dwc_pkg::ACTION_WIDTH-1:0]       s_action,
    input  logic signed [dwc_pkg::WORD_WIDTH-1:0]  s_data_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_popped_value,
    output logic [dwc_pkg::STATUS_WIDTH-1:0]       m_status,
    output logic [dwc_pkg::COUNT_WIDTH-1:0]        m_item_count,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_left_value,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_right_value,
    output logic signed [dwc_pkg::WORD_WIDTH-1:0]  m_cursor_value
);

    dwc_pkg::dwc_cmd_t cmd;

    // Sequencer
    dwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Store, indices and result register
    dwc_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_action       (s_action),
        .s_data_value   (s_data_value),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_item_count   (m_item_count),
        .m_left_value   (m_left_value),
        .m_right_value  (m_right_value),
        .m_cursor_value (m_cursor_value)
    );

    // Checks
    `DWC_ASSERT_ALWAYS(a_start_finish_excl, aclk, !(cmd.start && cmd.finish))
    `DWC_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `DWC_ASSERT(a_finish_loads, aclk, aresetn, cmd.finish |=> m_valid)
    `DWC_ASSERT(a_refused_push_pops_nothing, aclk, aresetn, (m_valid && (m_status == dwc_pkg::STATUS_FULL)) |-> (m_popped_value == '0))

endmodule

FILE: tb/deque_with_cursor_core_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_cursor_core_check
// Watches the request and result channels of the deque core. It keeps a
// shadow deque that is updated on every accepted request and compares each
// accepted result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module deque_with_cursor_core_check
    import dwc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [ACTION_WIDTH-1:0]        s_action,
    input  logic signed [WORD_WIDTH-1:0]   s_data_value,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [WORD_WIDTH-1:0]   m_popped_value,
    input  logic [STATUS_WIDTH-1:0]        m_status,
    input  logic [COUNT_WIDTH-1:0]         m_item_count,
    input  logic signed [WORD_WIDTH-1:0]   m_left_value,
    input  logic signed [WORD_WIDTH-1:0]   m_right_value,
    input  logic signed [WORD_WIDTH-1:0]   m_cursor_value,
    output int                             mismatches,
    output int                             results_owed
);

    localparam int CAP   = DEFAULT_CAPACITY;
    localparam int IDX_W = $clog2(CAP);

    // What one result should carry
    typedef struct {
        logic signed [WORD_WIDTH-1:0] popped;
        dwc_status_t                  status;
        logic [COUNT_WIDTH-1:0]       count;
        logic signed [WORD_WIDTH-1:0] left_word;
        logic signed [WORD_WIDTH-1:0] right_word;
        logic signed [WORD_WIDTH-1:0] cursor_word;
    } deque_view_t;

    // Shadow deque
    logic signed [WORD_WIDTH-1:0] shadow_slots [CAP];
    logic [IDX_W-1:0]             left_at;
    logic [IDX_W-1:0]             right_at;
    logic [IDX_W-1:0]             cursor_at;
    logic [COUNT_WIDTH-1:0]       held;

    deque_view_t owed_views [$];
    int          fail_total = 0;

    function automatic logic [IDX_W-1:0] ring_left(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(CAP - 1) : idx - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_right(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(CAP - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic int field_differs(input string field, input longint want,
                                         input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Apply one request to the shadow deque and build the result it gives
    task automatic predict_request(input dwc_action_t act,
                                   input logic signed [WORD_WIDTH-1:0] word,
                                   output deque_view_t view);
        view.popped = '0;
        view.status = STATUS_DONE;
        case (act)
            ACT_PUSH_LEFT, ACT_PUSH_RIGHT: begin
                if (held == CAP) begin
                    view.status = STATUS_FULL;
                end else if (held == 0) begin
                    // first word: both ends and the cursor land on it
                    shadow_slots[left_at] = word;
                    right_at  = left_at;
                    cursor_at = left_at;
                    held      = 1;
                end else if (act == ACT_PUSH_LEFT) begin
                    left_at = ring_left(left_at);
                    shadow_slots[left_at] = word;
                    held = held + 1'b1;
                end else begin
                    right_at = ring_right(right_at);
                    shadow_slots[right_at] = word;
                    held = held + 1'b1;
                end
            end
            ACT_POP_LEFT, ACT_POP_RIGHT: begin
                if (held == 0) begin
                    view.status = STATUS_EMPTY;
                end else if (held == 1) begin
                    // last word out: indices go back home
                    view.popped = shadow_slots[left_at];
                    left_at   = '0;
                    right_at  = '0;
                    cursor_at = '0;
                    held      = '0;
                end else if (act == ACT_POP_LEFT) begin
                    view.popped = shadow_slots[left_at];
                    if (cursor_at == left_at)
                        cursor_at = ring_right(cursor_at);
                    left_at = ring_right(left_at);
                    held = held - 1'b1;
                end else begin
                    view.popped = shadow_slots[right_at];
                    if (cursor_at == right_at)
                        cursor_at = ring_left(cursor_at);
                    right_at = ring_left(right_at);
                    held = held - 1'b1;
                end
            end
            ACT_CURSOR_LEFT: begin
                if (held < 2 || cursor_at == left_at)
                    view.status = STATUS_EDGE;
                else
                    cursor_at = ring_left(cursor_at);
            end
            ACT_CURSOR_RIGHT: begin
                if (held < 2 || cursor_at == right_at)
                    view.status = STATUS_EDGE;
                else
                    cursor_at = ring_right(cursor_at);
            end
            ACT_SET_CURSOR: begin
                if (held == 0)
                    view.status = STATUS_EMPTY;
                else
                    shadow_slots[cursor_at] = word;
            end
            default: begin
                if (held == 0)
                    view.status = STATUS_EMPTY;
            end
        endcase

        view.count = held;
        if (held == 0) begin
            view.left_word   = '0;
            view.right_word  = '0;
            view.cursor_word = '0;
        end else begin
            view.left_word   = shadow_slots[left_at];
            view.right_word  = shadow_slots[right_at];
            view.cursor_word = shadow_slots[cursor_at];
        end
    endtask

    // Retire results first, then record the new request
    always @(posedge aclk) begin : watch_channels
        deque_view_t want;
        if (!aresetn) begin
            left_at   = '0;
            right_at  = '0;
            cursor_at = '0;
            held      = '0;
            owed_views.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_views.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, got count %0d status %0d",
                             $time, m_item_count, m_status);
                    fail_total++;
                end else begin
                    want = owed_views.pop_front();
                    fail_total += field_differs("popped_value", want.popped, m_popped_value);
                    fail_total += field_differs("status", want.status, m_status);
                    fail_total += field_differs("item_count", want.count, m_item_count);
                    fail_total += field_differs("left_value", want.left_word, m_left_value);
                    fail_total += field_differs("right_value", want.right_word, m_right_value);
                    fail_total += field_differs("cursor_value", want.cursor_word,
                                                m_cursor_value);
                end
            end
            if (s_valid && s_ready) begin
                predict_request(dwc_action_t'(s_action), s_data_value, want);
                owed_views.push_back(want);
            end
        end
        mismatches   <= fail_total;
        results_owed <= owed_views.size();
    end

endmodule

FILE: tb/deque_with_cursor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_cursor_core_test
// Drives requests into the deque core: a directed pass over the empty, one
// word, edge and wrap cases, then a fill to capacity, a drain and a churn at
// small sizes, with bursty requests and a stalling result sink. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module deque_with_cursor_core_test;
    import dwc_pkg::*;

    localparam int CAP         = DEFAULT_CAPACITY;
    localparam int HOLD_CYCLES = 400;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [ACTION_WIDTH-1:0]       s_action       = ACT_STATUS;
    logic signed [WORD_WIDTH-1:0]  s_data_value   = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic signed [WORD_WIDTH-1:0]  m_popped_value;
    logic [STATUS_WIDTH-1:0]       m_status;
    logic [COUNT_WIDTH-1:0]        m_item_count;
    logic signed [WORD_WIDTH-1:0]  m_left_value;
    logic signed [WORD_WIDTH-1:0]  m_right_value;
    logic signed [WORD_WIDTH-1:0]  m_cursor_value;

    int mismatches;
    int results_owed;

    // Stimulus bookkeeping
    int words_held  = 0;
    int burst_left  = 0;
    int hold_asks   = 0;

    deque_with_cursor_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_data_value   (s_data_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_item_count   (m_item_count),
        .m_left_value   (m_left_value),
        .m_right_value  (m_right_value),
        .m_cursor_value (m_cursor_value)
    );

    deque_with_cursor_core_check deque_watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_data_value   (s_data_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_item_count   (m_item_count),
        .m_left_value   (m_left_value),
        .m_right_value  (m_right_value),
        .m_cursor_value (m_cursor_value),
        .mismatches     (mismatches),
        .results_owed   (results_owed)
    );

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("deque_with_cursor_core_test NOT OK");
        $finish;
    end

    // Result sink: stall pattern of its own, plus long hold-offs on request
    initial begin : result_sink
        int holds_served;
        int mode;
        int mode_left;
        holds_served = 0;
        mode         = 0;
        mode_left    = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ((mode_left % 12) < 8);
                endcase
            end
        end
    end

    // One request: optional gap at a burst boundary, then offer until taken
    task automatic send_request(input dwc_action_t act,
                                input logic signed [WORD_WIDTH-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_action     <= act;
        s_data_value <= word;
        do @(posedge aclk); while (!s_ready);
        case (act)
            ACT_PUSH_LEFT, ACT_PUSH_RIGHT: if (words_held < CAP) words_held++;
            ACT_POP_LEFT, ACT_POP_RIGHT:   if (words_held > 0) words_held--;
            default: ;
        endcase
    endtask

    // Weighted random request with random data
    task automatic random_request(input int push_pct, input int pop_pct);
        int          pick;
        dwc_action_t act;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            act = $urandom_range(0, 1) ? ACT_PUSH_RIGHT : ACT_PUSH_LEFT;
        end else if (pick < push_pct + pop_pct) begin
            act = $urandom_range(0, 1) ? ACT_POP_RIGHT : ACT_POP_LEFT;
        end else begin
            case ($urandom_range(0, 5))
                0, 1:    act = ACT_CURSOR_LEFT;
                2, 3:    act = ACT_CURSOR_RIGHT;
                4:       act = ACT_SET_CURSOR;
                default: act = ACT_STATUS;
            endcase
        end
        send_request(act, $urandom);
    endtask

    // Sender pause until every outstanding result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    initial begin : stimulus
        bit hold_issued;
        hold_issued = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty deque: every request is refused or reports empty
        send_request(ACT_STATUS,       32'sd0);
        send_request(ACT_POP_LEFT,     32'sd0);
        send_request(ACT_POP_RIGHT,    32'sd0);
        send_request(ACT_CURSOR_LEFT,  32'sd0);
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        send_request(ACT_SET_CURSOR,   32'sh1234_5678);
        // single word: cursor cannot move, popping it clears everything
        send_request(ACT_PUSH_LEFT,    32'sh8000_0000);
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        send_request(ACT_POP_RIGHT,    32'sd0);
        // build 5555 -1 7fff 0, cursor on 7fff
        send_request(ACT_PUSH_RIGHT,   32'sh7fff_ffff);
        send_request(ACT_PUSH_LEFT,    -32'sd1);
        send_request(ACT_PUSH_RIGHT,   32'sd0);
        send_request(ACT_PUSH_LEFT,    32'sh5555_5555);
        // walk the cursor into both ends
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        repeat (3) send_request(ACT_CURSOR_LEFT, 32'sd0);
        send_request(ACT_CURSOR_LEFT,  32'sd0);
        send_request(ACT_SET_CURSOR,   32'shaaaa_aaaa);
        // pop the word under the cursor from each end
        send_request(ACT_POP_LEFT,     32'sd0);
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        send_request(ACT_CURSOR_RIGHT, 32'sd0);
        send_request(ACT_POP_RIGHT,    32'sd0);
        send_request(ACT_POP_LEFT,     32'sd0);
        send_request(ACT_POP_LEFT,     32'sd0);
        send_request(ACT_STATUS,       32'sd0);
        wait_drained();

        // Fill to capacity; halfway up the sink holds off for a long stretch
        while (words_held < CAP) begin
            if (!hold_issued && words_held >= CAP / 2) begin
                hold_issued = 1'b1;
                hold_asks <= hold_asks + 1;
            end
            random_request(96, 2);
        end
        send_request(ACT_PUSH_LEFT,  $urandom);
        send_request(ACT_PUSH_RIGHT, $urandom);
        repeat (6) random_request(20, 0);
        wait_drained();

        // Drain down to a handful of words
        while (words_held > 6)
            random_request(2, 96);

        // Churn at small sizes, where the cursor hits both ends often
        repeat (30) begin
            if (words_held > 10)
                random_request(15, 45);
            else
                random_request(30, 25);
        end

        // Empty it again
        while (words_held > 0)
            random_request(0, 100);
        send_request(ACT_POP_LEFT, $urandom);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("deque_with_cursor_core_test OK");
        else
            $display("deque_with_cursor_core_test NOT OK");
        $finish;
    end

endmodule
